@@ hw/rtl/aat_pkg.sv @@
// ============================================================================
// aat_pkg
// Shared constants and types for the box affine transform unit: register
// indexes, register geometry and the per-stage advance strobes.
// ============================================================================
package aat_pkg;

    // Configuration register file geometry
    localparam int NUM_REGS  = 6;
    localparam int REG_W     = 64;
    localparam int HALF_W    = 32;
    localparam int CFG_IDX_W = 3;

    // Axes and matrix terms (three rows by three columns)
    localparam int NUM_AXES  = 3;
    localparam int NUM_TERMS = 9;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Register indexes
    localparam t_cfg_idx REG_ROW0_XY = 3'd0;
    localparam t_cfg_idx REG_ROW0_ZT = 3'd1;
    localparam t_cfg_idx REG_ROW1_XY = 3'd2;
    localparam t_cfg_idx REG_ROW1_ZT = 3'd3;
    localparam t_cfg_idx REG_ROW2_XY = 3'd4;
    localparam t_cfg_idx REG_ROW2_ZT = 3'd5;

    // Load strobes, one per pipeline stage
    typedef struct packed {
        logic corner;   // stage 1: corner coordinates
        logic mul;      // stage 2: products
        logic minmax;   // stage 3: floor and per-term min/max
        logic sum;      // stage 4: row sums
        logic out;      // stage 5: center/half and saturation
    } t_pipe_en;

endpackage

@@ hw/rtl/aat_cfg.sv @@
// ============================================================================
// aat_cfg
// Matrix register file. Holds the six 64-bit row registers and splits them
// into nine signed coefficients and three translations.
// ============================================================================
module aat_cfg #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr,
    input  aat_pkg::t_cfg_idx            i_idx,
    input  logic [aat_pkg::REG_W-1:0]    i_data,
    output logic signed [COORD_BITS-1:0] o_coef  [aat_pkg::NUM_TERMS],
    output logic signed [COORD_BITS-1:0] o_trans [aat_pkg::NUM_AXES]
);

    localparam logic [aat_pkg::REG_W-1:0] FIX_ONE = aat_pkg::REG_W'(1) << FRAC_BITS;

    logic [aat_pkg::REG_W-1:0] r_row [aat_pkg::NUM_REGS];

    // Register writes; unknown indexes are dropped. Reset gives identity.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[aat_pkg::REG_ROW0_XY] <= FIX_ONE;
            r_row[aat_pkg::REG_ROW0_ZT] <= '0;
            r_row[aat_pkg::REG_ROW1_XY] <= FIX_ONE << aat_pkg::HALF_W;
            r_row[aat_pkg::REG_ROW1_ZT] <= '0;
            r_row[aat_pkg::REG_ROW2_XY] <= '0;
            r_row[aat_pkg::REG_ROW2_ZT] <= FIX_ONE;
        end else if (i_wr) begin
            case (i_idx)
                aat_pkg::REG_ROW0_XY: r_row[aat_pkg::REG_ROW0_XY] <= i_data;
                aat_pkg::REG_ROW0_ZT: r_row[aat_pkg::REG_ROW0_ZT] <= i_data;
                aat_pkg::REG_ROW1_XY: r_row[aat_pkg::REG_ROW1_XY] <= i_data;
                aat_pkg::REG_ROW1_ZT: r_row[aat_pkg::REG_ROW1_ZT] <= i_data;
                aat_pkg::REG_ROW2_XY: r_row[aat_pkg::REG_ROW2_XY] <= i_data;
                aat_pkg::REG_ROW2_ZT: r_row[aat_pkg::REG_ROW2_ZT] <= i_data;
                default: begin
                end
            endcase
        end
    end

    // Row a: xy register holds m_a0 / m_a1, zt register holds m_a2 / t_a
    for (genvar a = 0; a < aat_pkg::NUM_AXES; a++) begin : g_row
        assign o_coef[a*3]     = r_row[2*a][COORD_BITS-1:0];
        assign o_coef[a*3 + 1] = r_row[2*a][aat_pkg::HALF_W +: COORD_BITS];
        assign o_coef[a*3 + 2] = r_row[2*a + 1][COORD_BITS-1:0];
        assign o_trans[a]      = r_row[2*a + 1][aat_pkg::HALF_W +: COORD_BITS];
    end

endmodule

@@ hw/rtl/aat_corner.sv @@
// ============================================================================
// aat_corner
// Stage 1: forms the low and high corner coordinate on each axis
// (center - half, center + half) at one bit more than the input width.
// ============================================================================
module aat_corner #(
    parameter int COORD_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [COORD_BITS-1:0] i_center [aat_pkg::NUM_AXES],
    input  logic [COORD_BITS-2:0]        i_half   [aat_pkg::NUM_AXES],
    output logic signed [COORD_BITS:0]   o_lo     [aat_pkg::NUM_AXES],
    output logic signed [COORD_BITS:0]   o_hi     [aat_pkg::NUM_AXES]
);

    logic signed [COORD_BITS:0] r_lo [aat_pkg::NUM_AXES];
    logic signed [COORD_BITS:0] r_hi [aat_pkg::NUM_AXES];
    logic signed [COORD_BITS:0] n_lo [aat_pkg::NUM_AXES];
    logic signed [COORD_BITS:0] n_hi [aat_pkg::NUM_AXES];

    // Corner extents, no saturation
    always_comb begin
        for (int a = 0; a < aat_pkg::NUM_AXES; a++) begin
            n_lo[a] = {i_center[a][COORD_BITS-1], i_center[a]} - {2'b00, i_half[a]};
            n_hi[a] = {i_center[a][COORD_BITS-1], i_center[a]} + {2'b00, i_half[a]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
    end

    assign o_lo = r_lo;
    assign o_hi = r_hi;

endmodule

@@ hw/rtl/aat_mul.sv @@
// ============================================================================
// aat_mul
// Stages 2 and 3: multiplies each coefficient by the low and high corner of
// its column, then floors the products to the fixed-point grid and keeps the
// smaller and larger of each pair.
// ============================================================================
module aat_mul #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_en_mul,
    input  logic                                     i_en_minmax,
    input  logic signed [COORD_BITS-1:0]             i_coef [aat_pkg::NUM_TERMS],
    input  logic signed [COORD_BITS:0]               i_lo   [aat_pkg::NUM_AXES],
    input  logic signed [COORD_BITS:0]               i_hi   [aat_pkg::NUM_AXES],
    output logic signed [2*COORD_BITS-FRAC_BITS:0]   o_min  [aat_pkg::NUM_TERMS],
    output logic signed [2*COORD_BITS-FRAC_BITS:0]   o_max  [aat_pkg::NUM_TERMS]
);

    localparam int PRW = 2*COORD_BITS + 1;      // exact product width
    localparam int SHW = PRW - FRAC_BITS;       // floored product width

    logic signed [PRW-1:0] r_plo [aat_pkg::NUM_TERMS];
    logic signed [PRW-1:0] r_phi [aat_pkg::NUM_TERMS];
    logic signed [PRW-1:0] n_plo [aat_pkg::NUM_TERMS];
    logic signed [PRW-1:0] n_phi [aat_pkg::NUM_TERMS];
    logic signed [SHW-1:0] r_min [aat_pkg::NUM_TERMS];
    logic signed [SHW-1:0] r_max [aat_pkg::NUM_TERMS];
    logic signed [SHW-1:0] n_min [aat_pkg::NUM_TERMS];
    logic signed [SHW-1:0] n_max [aat_pkg::NUM_TERMS];
    logic signed [SHW-1:0] w_flo [aat_pkg::NUM_TERMS];
    logic signed [SHW-1:0] w_fhi [aat_pkg::NUM_TERMS];

    // Term a*3+j: row a coefficient j times corner coordinate j
    always_comb begin
        for (int a = 0; a < aat_pkg::NUM_AXES; a++) begin
            for (int j = 0; j < aat_pkg::NUM_AXES; j++) begin
                n_plo[a*3 + j] = i_coef[a*3 + j] * i_lo[j];
                n_phi[a*3 + j] = i_coef[a*3 + j] * i_hi[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_plo <= n_plo;
            r_phi <= n_phi;
        end
    end

    // Dropping the fraction bits floors toward minus infinity
    always_comb begin
        for (int t = 0; t < aat_pkg::NUM_TERMS; t++) begin
            w_flo[t] = r_plo[t][PRW-1:FRAC_BITS];
            w_fhi[t] = r_phi[t][PRW-1:FRAC_BITS];
            if (w_flo[t] < w_fhi[t]) begin
                n_min[t] = w_flo[t];
                n_max[t] = w_fhi[t];
            end else begin
                n_min[t] = w_fhi[t];
                n_max[t] = w_flo[t];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_minmax) begin
            r_min <= n_min;
            r_max <= n_max;
        end
    end

    assign o_min = r_min;
    assign o_max = r_max;

endmodule

@@ hw/rtl/aat_sum.sv @@
// ============================================================================
// aat_sum
// Stages 4 and 5: adds the per-term extremes and the translation into the
// per-axis min and max, then forms center and half extent with saturation.
// ============================================================================
module aat_sum #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_en_sum,
    input  logic                                   i_en_out,
    input  logic signed [2*COORD_BITS-FRAC_BITS:0] i_min    [aat_pkg::NUM_TERMS],
    input  logic signed [2*COORD_BITS-FRAC_BITS:0] i_max    [aat_pkg::NUM_TERMS],
    input  logic signed [COORD_BITS-1:0]           i_trans  [aat_pkg::NUM_AXES],
    output logic signed [COORD_BITS-1:0]           o_center [aat_pkg::NUM_AXES],
    output logic [COORD_BITS-2:0]                  o_half   [aat_pkg::NUM_AXES]
);

    localparam int SHW  = 2*COORD_BITS + 1 - FRAC_BITS;
    localparam int SUMW = SHW + 2;              // three terms plus translation
    localparam int CMW  = SUMW + 1;             // min+max and max-min
    localparam logic signed [SUMW-1:0] CMAX =
        SUMW'((65'(1) << (COORD_BITS-1)) - 65'(1));
    localparam logic signed [SUMW-1:0] CMIN = -CMAX - SUMW'(1);

    logic signed [SUMW-1:0]       r_smin [aat_pkg::NUM_AXES];
    logic signed [SUMW-1:0]       r_smax [aat_pkg::NUM_AXES];
    logic signed [SUMW-1:0]       n_smin [aat_pkg::NUM_AXES];
    logic signed [SUMW-1:0]       n_smax [aat_pkg::NUM_AXES];
    logic signed [CMW-1:0]        w_add  [aat_pkg::NUM_AXES];
    logic signed [CMW-1:0]        w_diff [aat_pkg::NUM_AXES];
    logic signed [SUMW-1:0]       w_ctr  [aat_pkg::NUM_AXES];
    logic signed [SUMW-1:0]       w_hlf  [aat_pkg::NUM_AXES];
    logic signed [COORD_BITS-1:0] r_center [aat_pkg::NUM_AXES];
    logic [COORD_BITS-2:0]        r_half   [aat_pkg::NUM_AXES];
    logic signed [COORD_BITS-1:0] n_center [aat_pkg::NUM_AXES];
    logic [COORD_BITS-2:0]        n_half   [aat_pkg::NUM_AXES];

    // Row sums; min/max of a separable sum is the sum of per-term min/max
    always_comb begin
        for (int a = 0; a < aat_pkg::NUM_AXES; a++) begin
            n_smin[a] = i_min[a*3] + i_min[a*3 + 1] + i_min[a*3 + 2] + i_trans[a];
            n_smax[a] = i_max[a*3] + i_max[a*3 + 1] + i_max[a*3 + 2] + i_trans[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_sum) begin
            r_smin <= n_smin;
            r_smax <= n_smax;
        end
    end

    // Floored halves of sum and span, then clamp
    always_comb begin
        for (int a = 0; a < aat_pkg::NUM_AXES; a++) begin
            w_add[a]  = r_smax[a] + r_smin[a];
            w_diff[a] = r_smax[a] - r_smin[a];
            w_ctr[a]  = w_add[a][CMW-1:1];
            w_hlf[a]  = w_diff[a][CMW-1:1];
            if (w_ctr[a] > CMAX) begin
                n_center[a] = CMAX[COORD_BITS-1:0];
            end else if (w_ctr[a] < CMIN) begin
                n_center[a] = CMIN[COORD_BITS-1:0];
            end else begin
                n_center[a] = w_ctr[a][COORD_BITS-1:0];
            end
            // span is never negative, only the top needs a clamp
            if (w_hlf[a] > CMAX) begin
                n_half[a] = CMAX[COORD_BITS-2:0];
            end else begin
                n_half[a] = w_hlf[a][COORD_BITS-2:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_out) begin
            r_center <= n_center;
            r_half   <= n_half;
        end
    end

    assign o_center = r_center;
    assign o_half   = r_half;

endmodule

@@ hw/rtl/aabb_affine_transform_unit.sv @@
// ============================================================================
// aabb_affine_transform_unit
// Axis-aligned box through a 3x4 affine matrix in signed fixed point.
// ============================================================================
// Each accepted box passes the corner, mul, minmax, sum and out registers.
// Throughput: one box per cycle unless the output stalls; each of the five stages holds one box.
// Stage 2 (18 coefficient-by-corner multipliers) sets the critical path.
// A stalled output stops only the full stages in an unbroken run behind it.
// Reset (synchronous, active low) empties the pipeline and loads the
// identity matrix with zero translation.
module aabb_affine_transform_unit #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input boxes
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // center_x, center_y, center_z, half_x, half_y, half_z, zero pad
    input  logic [((6*COORD_BITS-3+7)/8)*8-1:0] s_axis_tdata,
    // transformed boxes
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // out_center_x/y/z, out_half_x/y/z, zero pad
    output logic [((6*COORD_BITS-3+7)/8)*8-1:0] m_axis_tdata,
    // matrix register writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  aat_pkg::t_cfg_idx                 i_cfg_index,
    input  logic [aat_pkg::REG_W-1:0]         i_cfg_data
);

    localparam int FIELDS_W = 6*COORD_BITS - 3;
    localparam int DATA_W   = ((FIELDS_W + 7) / 8) * 8;
    localparam int PAD_W    = DATA_W - FIELDS_W;
    localparam int SHW      = 2*COORD_BITS + 1 - FRAC_BITS;

    logic signed [COORD_BITS-1:0] w_coef   [aat_pkg::NUM_TERMS];
    logic signed [COORD_BITS-1:0] w_trans  [aat_pkg::NUM_AXES];
    logic signed [COORD_BITS-1:0] w_center [aat_pkg::NUM_AXES];
    logic [COORD_BITS-2:0]        w_half   [aat_pkg::NUM_AXES];
    logic signed [COORD_BITS:0]   w_lo     [aat_pkg::NUM_AXES];
    logic signed [COORD_BITS:0]   w_hi     [aat_pkg::NUM_AXES];
    logic signed [SHW-1:0]        w_min    [aat_pkg::NUM_TERMS];
    logic signed [SHW-1:0]        w_max    [aat_pkg::NUM_TERMS];
    logic signed [COORD_BITS-1:0] w_ocenter [aat_pkg::NUM_AXES];
    logic [COORD_BITS-2:0]        w_ohalf   [aat_pkg::NUM_AXES];

    logic [4:0]        r_vld;   // bit k: stage k+1 holds a box
    aat_pkg::t_pipe_en w_en;

    // Configuration is always accepted
    assign o_cfg_ready = 1'b1;

    aat_cfg #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_idx   (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_coef  (w_coef),
        .o_trans (w_trans)
    );

    // Input beat unpacking
    for (genvar a = 0; a < aat_pkg::NUM_AXES; a++) begin : g_unpack
        assign w_center[a] = s_axis_tdata[a*COORD_BITS +: COORD_BITS];
        assign w_half[a]   = s_axis_tdata[3*COORD_BITS + a*(COORD_BITS-1) +: COORD_BITS-1];
    end

    // Stage advance: a stage loads when it is empty or the next one loads
    always_comb begin
        w_en.out    = !r_vld[4] || m_axis_tready;
        w_en.sum    = !r_vld[3] || w_en.out;
        w_en.minmax = !r_vld[2] || w_en.sum;
        w_en.mul    = !r_vld[1] || w_en.minmax;
        w_en.corner = !r_vld[0] || w_en.mul;
    end

    assign s_axis_tready = w_en.corner;

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en.corner) r_vld[0] <= s_axis_tvalid;
            if (w_en.mul)    r_vld[1] <= r_vld[0];
            if (w_en.minmax) r_vld[2] <= r_vld[1];
            if (w_en.sum)    r_vld[3] <= r_vld[2];
            if (w_en.out)    r_vld[4] <= r_vld[3];
        end
    end

    aat_corner #(
        .COORD_BITS (COORD_BITS)
    ) u_corner (
        .i_clk    (i_clk),
        .i_en     (w_en.corner),
        .i_center (w_center),
        .i_half   (w_half),
        .o_lo     (w_lo),
        .o_hi     (w_hi)
    );

    aat_mul #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mul (
        .i_clk       (i_clk),
        .i_en_mul    (w_en.mul),
        .i_en_minmax (w_en.minmax),
        .i_coef      (w_coef),
        .i_lo        (w_lo),
        .i_hi        (w_hi),
        .o_min       (w_min),
        .o_max       (w_max)
    );

    aat_sum #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_sum (
        .i_clk    (i_clk),
        .i_en_sum (w_en.sum),
        .i_en_out (w_en.out),
        .i_min    (w_min),
        .i_max    (w_max),
        .i_trans  (w_trans),
        .o_center (w_ocenter),
        .o_half   (w_ohalf)
    );

    // Output beat packing
    assign m_axis_tvalid = r_vld[4];
    assign m_axis_tdata  = {{PAD_W{1'b0}},
                            w_ohalf[2], w_ohalf[1], w_ohalf[0],
                            w_ocenter[2], w_ocenter[1], w_ocenter[0]};

    // Pipeline checks
    a_rst_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_full_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld == 5'b11111) && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while every stage is full and stalled");

    a_empty_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[0] |-> s_axis_tready)
        else $error("input refused with an empty first stage");

    a_stall_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] && !m_axis_tready |=> r_vld[4] && $stable(w_ocenter[0]))
        else $error("stalled result lost or changed in the last stage");

endmodule
